// ===== hw/rtl/tpdl_pkg.sv =====
// Shared types and constants of the three-point distance linearizer.
// Used by the register file, the front end, the division cells and the top level.
package tpdl_pkg;

  localparam int RAW_W    = 16;
  localparam int TGT_W    = 9;
  localparam int FACTOR_W = 9;
  localparam int DVD_W    = RAW_W + FACTOR_W;
  localparam int ADDR_W   = 5;
  localparam int IDX_W    = 3;
  localparam int DATA_W   = 32;

  localparam logic [RAW_W-1:0] WIN100_LOW  = 16'd40;
  localparam logic [RAW_W-1:0] WIN100_HIGH = 16'd200;
  localparam logic [RAW_W-1:0] WIN300_LOW  = 16'd200;
  localparam logic [RAW_W-1:0] WIN300_HIGH = 16'd450;
  localparam logic [RAW_W-1:0] WIN500_LOW  = 16'd350;
  localparam logic [RAW_W-1:0] WIN500_HIGH = 16'd750;

  localparam logic [TGT_W-1:0] TGT_100_MM = 9'd100;
  localparam logic [TGT_W-1:0] TGT_300_MM = 9'd300;
  localparam logic [TGT_W-1:0] TGT_500_MM = 9'd500;

  localparam logic [IDX_W-1:0] REG_RAW_AT_100   = 3'd0;
  localparam logic [IDX_W-1:0] REG_RAW_AT_300   = 3'd1;
  localparam logic [IDX_W-1:0] REG_RAW_AT_500   = 3'd2;
  localparam logic [IDX_W-1:0] REG_POINT_MASK   = 3'd3;
  localparam logic [IDX_W-1:0] REG_DISPLAY_MAX  = 3'd4;
  localparam logic [IDX_W-1:0] REG_MIN_SEP_NEAR = 3'd5;
  localparam logic [IDX_W-1:0] REG_MIN_SEP_FAR  = 3'd6;

  typedef struct packed {
    logic [RAW_W-1:0] raw_at_100;
    logic [RAW_W-1:0] raw_at_300;
    logic [RAW_W-1:0] raw_at_500;
    logic [2:0]       point_valid_mask;
    logic [RAW_W-1:0] display_max;
    logic [RAW_W-1:0] min_sep_near;
    logic [RAW_W-1:0] min_sep_far;
  } cfg_t;

  typedef struct packed {
    logic             ok;
    logic             neg;
    logic [TGT_W-1:0] base;
    logic [RAW_W-1:0] dvs;
    logic [RAW_W-1:0] rem;
    logic [DVD_W-1:0] dq;
  } cell_t;

endpackage

// ===== hw/rtl/tpdl_regs.sv =====
// Configuration register file of the linearizer, reached through an APB-style port.
// Depends on tpdl_pkg for the register indexes and the configuration struct.
module tpdl_regs import tpdl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_at_100       <= 16'd100;
      cfg.raw_at_300       <= 16'd300;
      cfg.raw_at_500       <= 16'd500;
      cfg.point_valid_mask <= 3'd0;
      cfg.display_max      <= 16'd9999;
      cfg.min_sep_near     <= 16'd50;
      cfg.min_sep_far      <= 16'd50;
    end else if (wr_en) begin
      unique case (idx)
        REG_RAW_AT_100:   cfg.raw_at_100       <= pwdata[RAW_W-1:0];
        REG_RAW_AT_300:   cfg.raw_at_300       <= pwdata[RAW_W-1:0];
        REG_RAW_AT_500:   cfg.raw_at_500       <= pwdata[RAW_W-1:0];
        REG_POINT_MASK:   cfg.point_valid_mask <= pwdata[2:0];
        REG_DISPLAY_MAX:  cfg.display_max      <= pwdata[RAW_W-1:0];
        REG_MIN_SEP_NEAR: cfg.min_sep_near     <= pwdata[RAW_W-1:0];
        REG_MIN_SEP_FAR:  cfg.min_sep_far      <= pwdata[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RAW_AT_100:   prdata = {16'd0, cfg.raw_at_100};
      REG_RAW_AT_300:   prdata = {16'd0, cfg.raw_at_300};
      REG_RAW_AT_500:   prdata = {16'd0, cfg.raw_at_500};
      REG_POINT_MASK:   prdata = {29'd0, cfg.point_valid_mask};
      REG_DISPLAY_MAX:  prdata = {16'd0, cfg.display_max};
      REG_MIN_SEP_NEAR: prdata = {16'd0, cfg.min_sep_near};
      REG_MIN_SEP_FAR:  prdata = {16'd0, cfg.min_sep_far};
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/tpdl_front.sv =====
// Front end of the linearizer: point and segment selection, then the scaled and rounded dividend.
// Depends on tpdl_pkg; feeds the first division cell.
module tpdl_front import tpdl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [RAW_W-1:0] raw,
  input  cfg_t             cfg,
  output logic             out_vld,
  output cell_t            out_data
);

  localparam logic [1:0] SCALE_ONE  = 2'd0;
  localparam logic [1:0] SCALE_NEAR = 2'd1;
  localparam logic [1:0] SCALE_WIDE = 2'd2;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE  = 9'd1;
  localparam logic [FACTOR_W-1:0] FACTOR_NEAR = TGT_300_MM - TGT_100_MM;
  localparam logic [FACTOR_W-1:0] FACTOR_WIDE = TGT_500_MM - TGT_100_MM;

  logic             h1, h3, h5, p13, p35, p15;
  logic [RAW_W:0]   gap13, gap35, gap15, sep_sum, diff;
  logic             sel_ok;
  logic [RAW_W-1:0] sel_ra, sel_span;
  logic [TGT_W-1:0] sel_base;
  logic [1:0]       sel_scale;

  logic             a_vld, a_ok, a_neg;
  logic [TGT_W-1:0] a_base;
  logic [RAW_W-1:0] a_span, a_mag;
  logic [1:0]       a_scale;

  logic [FACTOR_W-1:0] factor;
  logic [DVD_W-1:0]    prod;
  cell_t               b_next;

  always_comb begin
    h1 = cfg.point_valid_mask[0] && (cfg.raw_at_100 >= WIN100_LOW)
         && (cfg.raw_at_100 <= WIN100_HIGH);
    h3 = cfg.point_valid_mask[1] && (cfg.raw_at_300 >= WIN300_LOW)
         && (cfg.raw_at_300 <= WIN300_HIGH);
    h5 = cfg.point_valid_mask[2] && (cfg.raw_at_500 >= WIN500_LOW)
         && (cfg.raw_at_500 <= WIN500_HIGH);
    gap13   = {1'b0, cfg.raw_at_300} - {1'b0, cfg.raw_at_100};
    gap35   = {1'b0, cfg.raw_at_500} - {1'b0, cfg.raw_at_300};
    gap15   = {1'b0, cfg.raw_at_500} - {1'b0, cfg.raw_at_100};
    sep_sum = {1'b0, cfg.min_sep_near} + {1'b0, cfg.min_sep_far};
    p13 = h1 && h3 && (cfg.raw_at_100 < cfg.raw_at_300)
          && (gap13 >= {1'b0, cfg.min_sep_near});
    p35 = h3 && h5 && (cfg.raw_at_300 < cfg.raw_at_500)
          && (gap35 >= {1'b0, cfg.min_sep_far});
    p15 = h1 && h5 && (cfg.raw_at_100 < cfg.raw_at_500) && (gap15 >= sep_sum);

    sel_ok    = 1'b1;
    sel_ra    = cfg.raw_at_100;
    sel_base  = TGT_100_MM;
    sel_span  = 16'd1;
    sel_scale = SCALE_ONE;
    if (p13 && (raw <= cfg.raw_at_300)) begin
      sel_span  = gap13[RAW_W-1:0];
      sel_scale = SCALE_NEAR;
    end else if (p35 && (raw >= cfg.raw_at_300)) begin
      sel_ra    = cfg.raw_at_300;
      sel_base  = TGT_300_MM;
      sel_span  = gap35[RAW_W-1:0];
      sel_scale = SCALE_NEAR;
    end else if (p15) begin
      sel_span  = gap15[RAW_W-1:0];
      sel_scale = SCALE_WIDE;
    end else if (p13) begin
      sel_span  = gap13[RAW_W-1:0];
      sel_scale = SCALE_NEAR;
    end else if (p35) begin
      sel_ra    = cfg.raw_at_300;
      sel_base  = TGT_300_MM;
      sel_span  = gap35[RAW_W-1:0];
      sel_scale = SCALE_NEAR;
    end else if (h3) begin
      sel_ra    = cfg.raw_at_300;
      sel_base  = TGT_300_MM;
    end else if (h1) begin
      sel_ra    = cfg.raw_at_100;
    end else if (h5) begin
      sel_ra    = cfg.raw_at_500;
      sel_base  = TGT_500_MM;
    end else begin
      sel_ok    = 1'b0;
    end
    diff = {1'b0, raw} - {1'b0, sel_ra};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_ok    <= sel_ok;
    a_neg   <= diff[RAW_W];
    a_mag   <= diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
    a_base  <= sel_base;
    a_span  <= sel_span;
    a_scale <= sel_scale;
  end

  always_comb begin
    case (a_scale)
      SCALE_NEAR: factor = FACTOR_NEAR;
      SCALE_WIDE: factor = FACTOR_WIDE;
      default:    factor = FACTOR_ONE;
    endcase
    prod        = DVD_W'(a_mag) * DVD_W'(factor);
    b_next.ok   = a_ok;
    b_next.neg  = a_neg;
    b_next.base = a_base;
    b_next.dvs  = a_span;
    b_next.rem  = '0;
    b_next.dq   = prod + DVD_W'(a_span >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= b_next;
  end

endmodule

// ===== hw/rtl/tpdl_cell.sv =====
// One restoring division cell: develops one quotient bit and passes the item to the next cell.
// Depends on tpdl_pkg for the cell payload struct.
module tpdl_cell import tpdl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_vld,
  input  cell_t in_data,
  output logic  out_vld,
  output cell_t out_data
);

  logic [RAW_W:0] trial;
  logic           take;
  cell_t          data_next;

  always_comb begin
    trial     = {in_data.rem, in_data.dq[DVD_W-1]};
    take      = trial >= {1'b0, in_data.dvs};
    data_next = in_data;
    data_next.rem = take ? RAW_W'(trial - {1'b0, in_data.dvs}) : trial[RAW_W-1:0];
    data_next.dq  = {in_data.dq[DVD_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

// ===== hw/rtl/three_point_distance_linearizer.sv =====
// Three-point distance linearizer: top level with register file, front end, division chain
// and output clamp. Depends on tpdl_pkg, tpdl_regs, tpdl_front and tpdl_cell.
//
// The block takes one raw reading in every clock cycle and returns its corrected distance
// through two front-end stages, the 25 division cells that develop one quotient bit apiece,
// and the output register. Results appear with done for one cycle in the order the readings
// came in, and the receiver cannot stall them. busy is high only during reset. The user must
// write registers only while no reading is in flight; the block itself does not enforce this.
module three_point_distance_linearizer import tpdl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [RAW_W-1:0]  raw_distance,
  output logic              done,
  output logic [RAW_W-1:0]  corrected_distance,
  output logic              ok,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int LATENCY = DVD_W + 3;

  cfg_t             cfg;
  logic [DVD_W:0]   chain_vld;
  cell_t            chain_data [DVD_W+1];
  cell_t            last;
  logic [DVD_W+1:0] val;
  logic [RAW_W-1:0] result_next;

  assign busy = rst;

  tpdl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpdl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (start && !busy),
    .raw      (raw_distance),
    .cfg      (cfg),
    .out_vld  (chain_vld[0]),
    .out_data (chain_data[0])
  );

  for (genvar i = 0; i < DVD_W; i++) begin : g_cell
    tpdl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (chain_vld[i]),
      .in_data  (chain_data[i]),
      .out_vld  (chain_vld[i+1]),
      .out_data (chain_data[i+1])
    );
  end

  always_comb begin
    last = chain_data[DVD_W];
    if (last.neg) begin
      val = (DVD_W+2)'(last.base) - (DVD_W+2)'(last.dq);
    end else begin
      val = (DVD_W+2)'(last.base) + (DVD_W+2)'(last.dq);
    end
    if (!last.ok || val[DVD_W+1]) begin
      result_next = '0;
    end else if (val[DVD_W:0] > (DVD_W+1)'(cfg.display_max)) begin
      result_next = cfg.display_max;
    end else begin
      result_next = val[RAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain_vld[DVD_W];
    end
  end

  always_ff @(posedge clk) begin
    corrected_distance <= result_next;
    ok                 <= last.ok;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted reading produced no result at the expected latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching accepted reading");

  a_zero_when_unusable: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (corrected_distance == '0))
    else $error("nonzero distance reported without a usable point");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> (corrected_distance <= cfg.display_max))
    else $error("corrected distance above display_max");
`endif

endmodule
